/* hdl/ipv4_lpm_pkg.sv */
// Shared types and constants for the IPv4 longest-prefix-match route table.
// Used by the table cells, the controller and the top level; no dependencies.
package ipv4_lpm_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int ADDR_W        = 32;
  localparam int LEN_W         = 6;
  localparam int PORT_W        = 8;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;
  localparam logic [1:0] MODE_LOOKUP = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_MISSING = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  prefix_len;
    logic [ADDR_W-1:0] next_hop_in;
    logic [PORT_W-1:0] port_in;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] next_hop_out;
    logic [PORT_W-1:0] port_out;
    logic [1:0]        status;
  } out_t;

  // Query and running match state passed from cell to cell
  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] pfx;
    logic [LEN_W-1:0]  len;
    logic              hit;
    idx_t              hit_idx;
    logic [LEN_W-1:0]  hit_len;
    logic [ADDR_W-1:0] hit_nh;
    logic [PORT_W-1:0] hit_port;
    logic              free_ok;
    idx_t              free_idx;
  } carry_t;

  // Slot write broadcast to every cell
  typedef struct packed {
    logic              en;
    logic              del;
    idx_t              idx;
    logic [ADDR_W-1:0] pfx;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] nh;
    logic [PORT_W-1:0] port;
  } wr_t;

  // Keeps the leading len bits; len is 0..32
  function automatic logic [ADDR_W-1:0] lead_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len == '0) begin
      m = '0;
    end else begin
      m = {ADDR_W{1'b1}} << (MAX_LEN - len);
    end
    return m;
  endfunction

endpackage

/* hdl/ipv4_lpm_cell.sv */
// One route slot of the table plus its stage of the compare chain.
// Depends on ipv4_lpm_pkg.
module ipv4_lpm_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ipv4_lpm_pkg::idx_t   cell_idx,
  input  ipv4_lpm_pkg::carry_t carry_i,
  input  ipv4_lpm_pkg::wr_t    wr_i,
  output ipv4_lpm_pkg::carry_t carry_o
);
  import ipv4_lpm_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [ADDR_W-1:0] prefix_r;
  logic [LEN_W-1:0]  len_r;
  logic [ADDR_W-1:0] nh_r;
  logic [PORT_W-1:0] port_r;
  carry_t            carry_r;
  carry_t            carry_nxt;
  logic              sel;
  logic              exact;
  logic              covers;
  logic              take;

  always_comb begin
    exact  = valid_r && (len_r == carry_i.len) && (prefix_r == carry_i.pfx);
    covers = valid_r && ((carry_i.addr & lead_mask(len_r)) == prefix_r);
    // lookup keeps the lowest slot among equal lengths: strictly longer only
    if (carry_i.mode == MODE_LOOKUP) begin
      take = covers && (!carry_i.hit || (len_r > carry_i.hit_len));
    end else begin
      take = exact && !carry_i.hit;
    end

    carry_nxt = carry_i;
    if (take) begin
      carry_nxt.hit      = 1'b1;
      carry_nxt.hit_idx  = cell_idx;
      carry_nxt.hit_len  = len_r;
      carry_nxt.hit_nh   = nh_r;
      carry_nxt.hit_port = port_r;
    end
    if (!valid_r && !carry_i.free_ok) begin
      carry_nxt.free_ok  = 1'b1;
      carry_nxt.free_idx = cell_idx;
    end
  end

  assign sel       = wr_i.en && (wr_i.idx == cell_idx);
  assign valid_nxt = sel ? !wr_i.del : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
    if (sel && !wr_i.del) begin
      prefix_r <= wr_i.pfx;
      len_r    <= wr_i.len;
      nh_r     <= wr_i.nh;
      port_r   <= wr_i.port;
    end
  end

  assign carry_o = carry_r;

endmodule

/* hdl/ipv4_lpm_ctl.sv */
// Sequencer of the route table: takes a beat, feeds the cell chain, resolves
// the chain result into a slot write and a result beat. Depends on ipv4_lpm_pkg.
module ipv4_lpm_ctl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ipv4_lpm_pkg::in_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ipv4_lpm_pkg::out_t   out_data,
  output ipv4_lpm_pkg::carry_t head_o,
  input  ipv4_lpm_pkg::carry_t tail_i,
  output ipv4_lpm_pkg::wr_t    wr_o
);
  import ipv4_lpm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_SCAN    = 3'b010,
    ST_RESOLVE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  idx_t              cnt_r, cnt_nxt;
  in_t               qry_r, qry_nxt;
  logic [ADDR_W-1:0] pfx_r, pfx_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;
  logic              accept;
  logic              fire;
  logic [LEN_W-1:0]  len_sat;
  out_t              res;
  wr_t               wr;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign fire     = (state_r == ST_RESOLVE) && (!out_valid_r || !out_stall);
  assign len_sat  = (in_data.prefix_len > MAX_LEN) ? MAX_LEN : in_data.prefix_len;

  always_comb begin
    head_o          = '0;
    head_o.mode     = qry_r.mode;
    head_o.addr     = qry_r.address;
    head_o.pfx      = pfx_r;
    head_o.len      = qry_r.prefix_len;
  end

  // Turn the chain's findings into the result and the slot update
  always_comb begin
    res        = '0;
    res.status = STAT_MISSING;
    wr         = '0;
    wr.idx     = tail_i.hit_idx;
    wr.pfx     = pfx_r;
    wr.len     = qry_r.prefix_len;
    wr.nh      = qry_r.next_hop_in;
    wr.port    = qry_r.port_in;
    case (qry_r.mode)
      MODE_INSERT: begin
        if (tail_i.hit) begin
          wr.en      = fire;
          res.hit    = 1'b1;
          res.status = STAT_OK;
        end else if (tail_i.free_ok) begin
          wr.en      = fire;
          wr.idx     = tail_i.free_idx;
          res.hit    = 1'b1;
          res.status = STAT_OK;
        end else begin
          res.status = STAT_FULL;
        end
      end
      MODE_DELETE: begin
        if (tail_i.hit) begin
          wr.en      = fire;
          wr.del     = 1'b1;
          res.hit    = 1'b1;
          res.status = STAT_OK;
        end
      end
      MODE_SEARCH, MODE_LOOKUP: begin
        if (tail_i.hit) begin
          res.hit          = 1'b1;
          res.status       = STAT_OK;
          res.next_hop_out = tail_i.hit_nh;
          res.port_out     = tail_i.hit_port;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    qry_nxt       = qry_r;
    pfx_nxt       = pfx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          qry_nxt            = in_data;
          qry_nxt.prefix_len = len_sat;
          pfx_nxt            = in_data.address & lead_mask(len_sat);
          cnt_nxt            = '0;
          state_nxt          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r == IDX_W'(TABLE_ENTRIES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_RESOLVE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_RESOLVE: begin
        if (fire) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qry_r      <= qry_nxt;
    pfx_r      <= pfx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign wr_o      = wr;

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_SCAN)
    else $error("accepted beat did not start a chain scan");

  a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    wr_o.en |=> out_valid_r)
    else $error("slot written without a result beat");

  a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> cnt_r == '0)
    else $error("scan counter not cleared while idle");

  a_hit_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.hit |-> out_data_r.status == STAT_OK)
    else $error("hit reported with a failing status");

endmodule

/* hdl/ipv4_lpm_cell_row.sv */
// Row of route slots: TABLE_ENTRIES cells linked head to tail, the query and
// running best match moving one cell per clock. Depends on ipv4_lpm_pkg, ipv4_lpm_cell.
module ipv4_lpm_cell_row (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ipv4_lpm_pkg::carry_t head_i,
  input  ipv4_lpm_pkg::wr_t    wr_i,
  output ipv4_lpm_pkg::carry_t tail_o
);
  import ipv4_lpm_pkg::*;

  carry_t links [TABLE_ENTRIES+1];

  assign links[0] = head_i;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ipv4_lpm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .carry_i  (links[i]),
      .wr_i     (wr_i),
      .carry_o  (links[i+1])
    );
  end

  assign tail_o = links[TABLE_ENTRIES];

endmodule

/* hdl/ipv4_longest_prefix_match_table_core.sv */
// IPv4 longest-prefix-match route table, top level. Each accepted beat (insert,
// delete, exact search or lookup) walks a query through a chain of one cell per
// route slot, one cell per clock, then the resolve state picks the slot to write and
// forms the result. A new beat is accepted in the cycle after the result of the
// previous one is registered, not before, even while that result still waits on
// out_stall; the resolve state waits only if the previous result has not yet been
// taken. Slot valid bits clear at reset, so the table is ready at once. Depends on
// ipv4_lpm_pkg, ipv4_lpm_ctl and ipv4_lpm_cell_row.
module ipv4_longest_prefix_match_table_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ipv4_lpm_pkg::in_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ipv4_lpm_pkg::out_t out_data
);
  import ipv4_lpm_pkg::*;

  carry_t head;
  carry_t tail;
  wr_t    wr;

  ipv4_lpm_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .head_o    (head),
    .tail_i    (tail),
    .wr_o      (wr)
  );

  ipv4_lpm_cell_row u_row (
    .clk    (clk),
    .rst_n  (rst_n),
    .head_i (head),
    .wr_i   (wr),
    .tail_o (tail)
  );

endmodule
